// ===== design/tpsp_pkg.sv =====
// Shared types and constants for the three-phase sine PWM generator.
// Holds the sequencer state and command types and the polynomial coefficients.
// Used by tpsp_ctrl, tpsp_dpath and the top level; depends on nothing else.
package tpsp_pkg;

	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int IN_W  = 32;
	localparam int OUT_W = 96;
	localparam int CFG_W = 16;

	localparam logic [17:0] PERIOD_RPM_MS = 18'd180000;
	localparam logic [17:0] THIRD_RPM_MS  = 18'd60000;

	localparam logic [15:0] RPM_RESET   = 16'd5000;
	localparam logic [15:0] PULSE_RESET = 16'd50;

	// Odd polynomial for sin(pi/2 * u), Q1.30.
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	typedef enum logic [0:0] {
		REG_TARGET_RPM  = 1'b0,
		REG_PULSE_WIDTH = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ELAP, ST_CHECK, ST_PHASE, ST_IDX_MUL, ST_IDX_EST, ST_IDX_COR,
		ST_QUAD, ST_U_MUL, ST_U_EST, ST_U_COR, ST_SQ, ST_H9, ST_H7, ST_H5, ST_H3,
		ST_H1, ST_RND, ST_PW_MUL, ST_PW_CMP, ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ELAP, OP_CHECK, OP_PHASE, OP_IDX_MUL, OP_IDX_EST,
		OP_IDX_COR, OP_QUAD, OP_U_MUL, OP_U_EST, OP_U_COR, OP_SQ, OP_H9, OP_H7,
		OP_H5, OP_H3, OP_H1, OP_RND, OP_PW_MUL, OP_PW_CMP, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] phase;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} status_t;

endpackage

// ===== design/tpsp_ctrl.sv =====
// Sequencer for the three-phase sine PWM generator.
// Steps the datapath through one word and owns both stream handshakes.
// Depends on tpsp_pkg.
module tpsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  tpsp_pkg::status_t  status,
	output tpsp_pkg::cmd_t     cmd
);
	import tpsp_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       m_valid_q;
	logic       load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= 2'd0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		load_out  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.phase = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_ELAP;
				end
			end
			ST_ELAP: begin
				cmd.op  = OP_ELAP;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.op  = OP_CHECK;
				phase_d = 2'd0;
				state_d = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.op  = OP_PHASE;
				state_d = ST_IDX_MUL;
			end
			ST_IDX_MUL: begin
				cmd.op  = OP_IDX_MUL;
				state_d = ST_IDX_EST;
			end
			ST_IDX_EST: begin
				cmd.op  = OP_IDX_EST;
				state_d = ST_IDX_COR;
			end
			ST_IDX_COR: begin
				cmd.op  = OP_IDX_COR;
				state_d = ST_QUAD;
			end
			ST_QUAD: begin
				// The negative half of the wave clamps to zero, so the polynomial is skipped.
				cmd.op  = OP_QUAD;
				state_d = status.skip ? ST_RND : ST_U_MUL;
			end
			ST_U_MUL: begin
				cmd.op  = OP_U_MUL;
				state_d = ST_U_EST;
			end
			ST_U_EST: begin
				cmd.op  = OP_U_EST;
				state_d = ST_U_COR;
			end
			ST_U_COR: begin
				cmd.op  = OP_U_COR;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op  = OP_SQ;
				state_d = ST_H9;
			end
			ST_H9: begin
				cmd.op  = OP_H9;
				state_d = ST_H7;
			end
			ST_H7: begin
				cmd.op  = OP_H7;
				state_d = ST_H5;
			end
			ST_H5: begin
				cmd.op  = OP_H5;
				state_d = ST_H3;
			end
			ST_H3: begin
				cmd.op  = OP_H3;
				state_d = ST_H1;
			end
			ST_H1: begin
				cmd.op  = OP_H1;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.op = OP_RND;
				if (phase_q == 2'd2) begin
					phase_d = 2'd0;
					state_d = ST_PW_MUL;
				end else begin
					phase_d = phase_q + 2'd1;
					state_d = ST_PHASE;
				end
			end
			ST_PW_MUL: begin
				cmd.op  = OP_PW_MUL;
				state_d = ST_PW_CMP;
			end
			ST_PW_CMP: begin
				cmd.op = OP_PW_CMP;
				if (phase_q == 2'd2) begin
					phase_d = 2'd0;
					state_d = ST_DONE;
				end else begin
					phase_d = phase_q + 2'd1;
					state_d = ST_PW_MUL;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					cmd.op   = OP_OUT;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ELAP && !s_tready))
		else $error("accepted word did not start the sequence");
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
		else $error("finished word not presented on the output");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("phase counter out of range");
`endif

endmodule

// ===== design/tpsp_dpath.sv =====
// Datapath of the three-phase sine PWM generator: timing state, phase index,
// sine polynomial on a shared multiplier, line values and the three PWM gates.
// Depends on tpsp_pkg; driven by tpsp_ctrl commands.
module tpsp_dpath #(
	parameter int SINE_TABLE_ENTRIES = tpsp_pkg::SINE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpsp_pkg::cmd_t                cmd,
	output tpsp_pkg::status_t             status,
	input  logic [tpsp_pkg::IN_W-1:0]     s_tdata,
	output logic [tpsp_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [tpsp_pkg::CFG_W-1:0]    cfg_data
);
	import tpsp_pkg::*;

	localparam int N   = SINE_TABLE_ENTRIES;
	localparam int IW  = $clog2(N);
	localparam int NW  = $clog2(N + 1);
	localparam int QW  = IW + 2;
	localparam int XW  = 18 + NW;
	localparam int YW  = 2 * NW;
	localparam logic [63:0] M1 = (64'd1 << XW) / 64'd180000;
	localparam int M1W = $clog2(M1 + 64'd1);
	localparam logic [63:0] M2 = (64'd1 << YW) / 64'(N);
	localparam int M2W = $clog2(M2 + 64'd1);
	localparam logic [30:0]   U_A  = 31'((64'd1 << 30) / 64'(N));
	localparam logic [NW-1:0] U_B  = NW'((64'd1 << 30) % 64'(N));
	localparam logic [QW-1:0] N1_Q = QW'(N);
	localparam logic [QW-1:0] N2_Q = QW'(2 * N);

	// Control state
	logic [15:0] rpm_q, pw_q;
	logic [31:0] run_start_q;
	logic [31:0] stamp_q [3];

	// Working registers
	logic [31:0]        now_q;
	logic [47:0]        prod_q;
	logic [17:0]        e_q, v_q;
	logic [XW-1:0]      x_q;
	logic [NW-1:0]      est_q;
	logic [IW-1:0]      p_q;
	logic [NW-1:0]      r_q;
	logic               zero_q;
	logic [30:0]        ra_q, u_q, u2_q, t_q, s_q;
	logic [YW-1:0]      y_q;
	logic [14:0]        h_q [3];
	logic [31:0]        dt_q, pp_q;
	logic [2:0]         pwm_q;
	logic [OUT_W-1:0]   out_q;

	logic [31:0]          elapsed;
	logic                 restart;
	logic [18:0]          v_off, v_sum;
	logic [17:0]          v_red;
	logic [XW+M1W-1:0]    est1_full;
	logic [XW-1:0]        rem1;
	logic [QW-1:0]        q4;
	logic [NW-1:0]        r_next;
	logic [YW+M2W-1:0]    est2_full;
	logic [YW-1:0]        rem2;
	logic [30:0]          hm_a, hm_b, hm_hi, hm_c;
	logic [61:0]          hm_full;
	logic [16:0]          rnd;
	logic [14:0]          h_next;
	logic signed [15:0]   line_a, line_b, line_c, line_sel;
	logic [15:0]          duty;
	logic [31:0]          stamp_sel;
	logic [47:0]          dt65;

	assign elapsed = now_q - run_start_q;
	assign restart = prod_q > 48'(PERIOD_RPM_MS);

	always_comb begin
		unique case (cmd.phase)
			2'd0:    v_off = 19'd0;
			2'd1:    v_off = 19'(THIRD_RPM_MS);
			default: v_off = 19'(THIRD_RPM_MS) << 1;
		endcase
	end
	assign v_sum = 19'(e_q) + v_off;
	assign v_red = (v_sum >= 19'(PERIOD_RPM_MS)) ? 18'(v_sum - 19'(PERIOD_RPM_MS))
		: v_sum[17:0];

	// Reciprocal estimate of x / 180000, at most one short of the true quotient.
	assign est1_full = (XW+M1W)'(x_q) * (XW+M1W)'(M1[M1W-1:0]);
	assign rem1 = x_q - XW'(XW'(est_q) * XW'(PERIOD_RPM_MS));

	assign q4 = {p_q, 2'b00};
	assign status.skip = (q4 >= N2_Q);
	assign r_next = (q4 >= N1_Q) ? NW'(N2_Q - q4) : NW'(q4);

	// Remainder part of r * 2^30 / N, again one short at most.
	assign est2_full = (YW+M2W)'(y_q) * (YW+M2W)'(M2[M2W-1:0]);
	assign rem2 = y_q - YW'(YW'(est_q) * YW'(N));

	// One multiplier serves the square and every Horner step.
	always_comb begin
		unique case (cmd.op)
			OP_SQ: begin
				hm_a = u_q;
				hm_b = u_q;
			end
			OP_H9: begin
				hm_a = u2_q;
				hm_b = SIN_C9;
			end
			OP_H1: begin
				hm_a = u_q;
				hm_b = t_q;
			end
			default: begin
				hm_a = u2_q;
				hm_b = t_q;
			end
		endcase
	end
	assign hm_full = 62'(hm_a) * 62'(hm_b);
	assign hm_hi   = hm_full[60:30];

	always_comb begin
		unique case (cmd.op)
			OP_H7:   hm_c = SIN_C5;
			OP_H5:   hm_c = SIN_C3;
			OP_H3:   hm_c = SIN_C1;
			default: hm_c = SIN_C7;
		endcase
	end

	assign rnd    = {1'b0, s_q[30:15]} + 17'(s_q[14]);
	assign h_next = zero_q ? 15'd0 : ((rnd > 17'd32767) ? 15'h7fff : rnd[14:0]);

	assign line_a = $signed({1'b0, h_q[0]}) - $signed({1'b0, h_q[1]});
	assign line_b = $signed({1'b0, h_q[1]}) - $signed({1'b0, h_q[2]});
	assign line_c = $signed({1'b0, h_q[2]}) - $signed({1'b0, h_q[0]});

	always_comb begin
		unique case (cmd.phase)
			2'd0: begin
				line_sel  = line_a;
				stamp_sel = stamp_q[0];
			end
			2'd1: begin
				line_sel  = line_b;
				stamp_sel = stamp_q[1];
			end
			default: begin
				line_sel  = line_c;
				stamp_sel = stamp_q[2];
			end
		endcase
	end

	// A positive line below 2^15 scaled by 65535/32768 and floored is 2*line - 1.
	assign duty = (line_sel > 16'sd0) ? ({line_sel[14:0], 1'b0} - 16'd1) : 16'd0;
	assign dt65 = {dt_q, 16'd0} - {16'd0, dt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_q       <= RPM_RESET;
			pw_q        <= PULSE_RESET;
			run_start_q <= 32'd0;
			for (int k = 0; k < 3; k++) begin
				stamp_q[k] <= 32'd0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET_RPM:  rpm_q <= cfg_data;
					REG_PULSE_WIDTH: pw_q  <= cfg_data;
				endcase
			end
			if (cmd.op == OP_CHECK && restart) begin
				run_start_q <= now_q;
			end
			if (cmd.op == OP_PW_CMP) begin
				for (int k = 0; k < 3; k++) begin
					if (cmd.phase == 2'(k) && dt_q > {16'd0, pw_q}) begin
						stamp_q[k] <= now_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD:    now_q  <= s_tdata;
			OP_ELAP:    prod_q <= 48'(elapsed) * 48'(rpm_q);
			OP_CHECK:   e_q    <= restart ? 18'd0 : prod_q[17:0];
			OP_PHASE:   v_q    <= v_red;
			OP_IDX_MUL: x_q    <= XW'(XW'(v_q) * XW'(N));
			OP_IDX_EST: est_q  <= NW'(est1_full >> XW);
			OP_IDX_COR: p_q    <= IW'(est_q + NW'(rem1 >= XW'(PERIOD_RPM_MS)));
			OP_QUAD: begin
				r_q    <= r_next;
				zero_q <= status.skip;
			end
			OP_U_MUL: begin
				ra_q <= 31'(32'(r_q) * 32'(U_A));
				y_q  <= YW'(YW'(r_q) * YW'(U_B));
			end
			OP_U_EST:   est_q <= NW'(est2_full >> YW);
			OP_U_COR:   u_q   <= ra_q + 31'(est_q) + 31'(rem2 >= YW'(N));
			OP_SQ:      u2_q  <= hm_hi;
			OP_H9, OP_H7, OP_H5, OP_H3: t_q <= hm_c - hm_hi;
			OP_H1:      s_q   <= hm_hi;
			OP_RND: begin
				for (int k = 0; k < 3; k++) begin
					if (cmd.phase == 2'(k)) begin
						h_q[k] <= h_next;
					end
				end
			end
			OP_PW_MUL: begin
				pp_q <= 32'(pw_q) * 32'(duty);
				dt_q <= now_q - stamp_sel;
			end
			OP_PW_CMP: begin
				// dt <= floor(pw * duty / 65535) is the same as dt * 65535 <= pw * duty.
				for (int k = 0; k < 3; k++) begin
					if (cmd.phase == 2'(k)) begin
						pwm_q[k] <= (dt65 <= {16'd0, pp_q});
					end
				end
			end
			OP_OUT: begin
				out_q <= {h_q[2], h_q[1], h_q[0], line_c, line_b, line_a, pwm_q};
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = out_q;

`ifndef SYNTH
	a_elapsed_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CHECK) |=> (e_q <= PERIOD_RPM_MS))
		else $error("scaled elapsed time beyond one electrical period");
	a_u_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_U_COR) |=> (u_q <= 31'h4000_0000))
		else $error("quarter-wave argument above one");
`endif

endmodule

// ===== design/three_phase_sine_pwm_generator.sv =====
// Three-phase sine PWM generator, top level. One word is handled at a time: the sequencer makes
// three passes through the shared sine multiplier, one per phase, then computes the three PWM
// gates (a phase in the negative half wave skips the polynomial, which happens for one or two
// of the three phases).
// A finished result waits in the output register while the next word is taken.
// arst_n clears the run start, the three toggle stamps and the handshakes; rpm and pulse width
// return to 5000 and 50.
module three_phase_sine_pwm_generator #(
	parameter int SINE_TABLE_ENTRIES = tpsp_pkg::SINE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tpsp_pkg::IN_W-1:0]     s_tdata,   // now_ms
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pwm_a, pwm_b, pwm_c, line_a, line_b, line_c, half_first, half_second, half_third
	output logic [tpsp_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [tpsp_pkg::CFG_W-1:0]    cfg_data
);
	import tpsp_pkg::*;

	cmd_t    cmd;
	status_t status;

	tpsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tpsp_dpath #(
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
